// File: rtl/rct_pkg.sv
`timescale 1ns / 1ps

package rct_pkg;

  // Fixed field widths
  localparam int MODE_W    = 2;
  localparam int RUN_W     = 7;
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 30;

  // Limb size of the shared multipliers
  localparam int LIMB_W  = 32;
  localparam int LIMB_SH = 5;

  // Command queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QFILL_W = 2;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_DIR_PT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INV_PT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIR_ROW = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INV_ROW = 2'd3;

  // Register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_COS       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIN       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_X_OFF     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_OFF     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_X_OFF_INV = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_Y_OFF_INV = 3'd5;

  // 1.0 in Q1.30
  localparam logic [COEF_W-1:0] COS_RESET = 32'h4000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YTERM,
    ST_XTERM,
    ST_ROUND
  } eng_state_t;

  // Classified item as it waits in the queue
  typedef struct packed {
    logic             inv;
    logic [RUN_W-1:0] count;
  } rct_cmd_t;

endpackage

// File: rtl/rct_front.sv
`timescale 1ns / 1ps

module rct_front #(
  parameter int MAX_RUN     = 64,
  parameter int COORD_WIDTH = 48
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   s_tvalid,
  output logic                                                   s_tready,
  input  logic [((3*COORD_WIDTH + rct_pkg::RUN_W + 7)/8)*8-1:0] s_tdata,
  input  logic [rct_pkg::MODE_W-1:0]                             s_tuser,
  output logic                                                   q_valid,
  input  logic                                                   q_pop,
  output rct_pkg::rct_cmd_t                                      q_cmd,
  output logic [COORD_WIDTH-1:0]                                 q_x,
  output logic [COORD_WIDTH-1:0]                                 q_y,
  output logic [COORD_WIDTH-1:0]                                 q_step
);

  logic [COORD_WIDTH-1:0]    in_x;
  logic [COORD_WIDTH-1:0]    in_y;
  logic [COORD_WIDTH-1:0]    in_step;
  logic [rct_pkg::RUN_W-1:0] in_run;
  logic [rct_pkg::RUN_W-1:0] run_clip;
  rct_pkg::rct_cmd_t         cmd;
  logic                      push;

  rct_pkg::rct_cmd_t         cmd_mem  [rct_pkg::QDEPTH];
  logic [COORD_WIDTH-1:0]    x_mem    [rct_pkg::QDEPTH];
  logic [COORD_WIDTH-1:0]    y_mem    [rct_pkg::QDEPTH];
  logic [COORD_WIDTH-1:0]    step_mem [rct_pkg::QDEPTH];
  logic [rct_pkg::QPTR_W-1:0]  wr_ptr;
  logic [rct_pkg::QPTR_W-1:0]  rd_ptr;
  logic [rct_pkg::QFILL_W-1:0] fill;

  assign in_x    = s_tdata[0 +: COORD_WIDTH];
  assign in_y    = s_tdata[COORD_WIDTH +: COORD_WIDTH];
  assign in_step = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
  assign in_run  = s_tdata[3*COORD_WIDTH +: rct_pkg::RUN_W];

  assign run_clip = (in_run > rct_pkg::RUN_W'(MAX_RUN)) ? rct_pkg::RUN_W'(MAX_RUN) : in_run;

  // Classify: a point is a run of one
  always_comb begin
    cmd = '0;
    unique case (s_tuser)
      rct_pkg::MODE_DIR_PT: begin
        cmd.inv   = 1'b0;
        cmd.count = rct_pkg::RUN_W'(1);
      end
      rct_pkg::MODE_INV_PT: begin
        cmd.inv   = 1'b1;
        cmd.count = rct_pkg::RUN_W'(1);
      end
      rct_pkg::MODE_DIR_ROW: begin
        cmd.inv   = 1'b0;
        cmd.count = run_clip;
      end
      rct_pkg::MODE_INV_ROW: begin
        cmd.inv   = 1'b1;
        cmd.count = run_clip;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign s_tready = (fill != rct_pkg::QFILL_W'(rct_pkg::QDEPTH));
  // Drop empty rows here
  assign push     = s_tvalid && s_tready && (cmd.count != '0);
  assign q_valid  = (fill != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rct_pkg::QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + rct_pkg::QPTR_W'(1);
      end
      if (push && !q_pop) begin
        fill <= fill + rct_pkg::QFILL_W'(1);
      end else if (!push && q_pop) begin
        fill <= fill - rct_pkg::QFILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem[wr_ptr]  <= cmd;
      x_mem[wr_ptr]    <= in_x;
      y_mem[wr_ptr]    <= in_y;
      step_mem[wr_ptr] <= in_step;
    end
  end

  assign q_cmd  = cmd_mem[rd_ptr];
  assign q_x    = x_mem[rd_ptr];
  assign q_y    = y_mem[rd_ptr];
  assign q_step = step_mem[rd_ptr];

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= rct_pkg::QFILL_W'(rct_pkg::QDEPTH))
    else $error("queue fill beyond depth");

  a_queued_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_cmd.count != '0))
    else $error("queued item with zero points");

endmodule

// File: rtl/rct_engine.sv
`timescale 1ns / 1ps

module rct_engine #(
  parameter int MAX_RUN     = 64,
  parameter int COORD_WIDTH = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  rct_pkg::rct_cmd_t                 q_cmd,
  input  logic [COORD_WIDTH-1:0]            q_x,
  input  logic [COORD_WIDTH-1:0]            q_y,
  input  logic [COORD_WIDTH-1:0]            q_step,
  input  logic signed [rct_pkg::COEF_W-1:0] cos_coef,
  input  logic signed [rct_pkg::COEF_W-1:0] sin_coef,
  input  logic [COORD_WIDTH-1:0]            x_offset,
  input  logic [COORD_WIDTH-1:0]            y_offset,
  input  logic [COORD_WIDTH-1:0]            x_offset_inv,
  input  logic [COORD_WIDTH-1:0]            y_offset_inv,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [COORD_WIDTH-1:0]            out_x,
  output logic [COORD_WIDTH-1:0]            out_y,
  output logic                              out_last,
  output logic                              out_sat
);

  // Row x grows by up to MAX_RUN-1 steps and is kept exact
  localparam int XW    = COORD_WIDTH + $clog2(MAX_RUN) + 1;
  localparam int NCH   = (XW + rct_pkg::LIMB_W - 1) / rct_pkg::LIMB_W;
  localparam int OPW   = NCH * rct_pkg::LIMB_W;
  localparam int ACCW  = XW + rct_pkg::COEF_W + 1;
  localparam int PW    = rct_pkg::LIMB_W + 1 + rct_pkg::COEF_W;
  localparam int CNT_W = $clog2(MAX_RUN + 1);
  localparam int PH_W  = $clog2(NCH + 1);
  localparam int SH_W  = PH_W + rct_pkg::LIMB_SH;

  rct_pkg::eng_state_t state;
  rct_pkg::eng_state_t state_next;

  logic [PH_W-1:0]         cnt;
  logic [CNT_W-1:0]        count;
  logic                    inv;
  logic signed [XW-1:0]    cur_x;
  logic signed [XW-1:0]    step_x;
  logic signed [XW-1:0]    cur_x_next;
  logic signed [OPW-1:0]   opnd;
  logic signed [PW-1:0]    prod_c;
  logic signed [PW-1:0]    prod_s;
  logic signed [ACCW-1:0]  acc_a;
  logic signed [ACCW-1:0]  acc_b;
  logic signed [ACCW-1:0]  held_a;
  logic signed [ACCW-1:0]  held_b;
  logic signed [ACCW-1:0]  acc_a_next;
  logic signed [ACCW-1:0]  acc_b_next;
  logic signed [ACCW-1:0]  term_c;
  logic signed [ACCW-1:0]  term_s;
  logic signed [ACCW-1:0]  term_s_sgn;
  logic signed [ACCW-1:0]  off_a;
  logic signed [ACCW-1:0]  off_b;
  logic [SH_W-1:0]         shamt;
  logic [rct_pkg::LIMB_W-1:0] limb;
  logic signed [rct_pkg::LIMB_W:0] limb_s;
  logic                    in_mul;
  logic                    issue;
  logic                    ph_end;
  logic                    neg_s;
  logic                    out_free;
  logic                    out_load;
  logic [COORD_WIDTH:0]    fin_x;
  logic [COORD_WIDTH:0]    fin_y;

  // Round to nearest (ties up) at COEF_FRAC bits, clip to the coordinate range.
  // Returns {clipped, value}.
  function automatic logic [COORD_WIDTH:0] finish(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0]                          r;
    logic [ACCW-COORD_WIDTH-rct_pkg::COEF_FRAC:0]    hi;
    logic                                            sat;
    logic [COORD_WIDTH-1:0]                          val;
    r   = v + (ACCW'(1) << (rct_pkg::COEF_FRAC - 1));
    hi  = r[ACCW-1 : COORD_WIDTH-1+rct_pkg::COEF_FRAC];
    sat = !((&hi) || !(|hi));
    if (sat) begin
      val = r[ACCW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      val = r[rct_pkg::COEF_FRAC +: COORD_WIDTH];
    end
    return {sat, val};
  endfunction

  assign in_mul   = (state == rct_pkg::ST_YTERM) || (state == rct_pkg::ST_XTERM);
  assign issue    = in_mul && (cnt < PH_W'(NCH));
  assign ph_end   = in_mul && (cnt == PH_W'(NCH));
  assign out_free = !m_tvalid || m_tready;

  // Low limbs are unsigned, the top limb carries the sign
  assign limb   = opnd[rct_pkg::LIMB_W-1:0];
  assign limb_s = {(cnt == PH_W'(NCH - 1)) & limb[rct_pkg::LIMB_W-1], limb};

  assign shamt  = {cnt - PH_W'(1), {rct_pkg::LIMB_SH{1'b0}}};
  assign term_c = ACCW'(prod_c) << shamt;
  assign term_s = ACCW'(prod_s) << shamt;

  // Y pass: sine product feeds the x-term, negated for the direct mapping.
  // X pass: sine product feeds the y-term, negated for the inverse mapping.
  assign neg_s      = (state == rct_pkg::ST_YTERM) ? !inv : inv;
  assign term_s_sgn = neg_s ? -term_s : term_s;

  always_comb begin
    acc_a_next = acc_a;
    acc_b_next = acc_b;
    if (in_mul && (cnt != '0)) begin
      if (state == rct_pkg::ST_YTERM) begin
        acc_a_next = acc_a + term_s_sgn;
        acc_b_next = acc_b + term_c;
      end else begin
        acc_a_next = acc_a + term_c;
        acc_b_next = acc_b + term_s_sgn;
      end
    end
  end

  assign off_a = (ACCW'($signed(q_cmd.inv ? x_offset_inv : x_offset))) <<< rct_pkg::COEF_FRAC;
  assign off_b = (ACCW'($signed(q_cmd.inv ? y_offset_inv : y_offset))) <<< rct_pkg::COEF_FRAC;

  assign cur_x_next = cur_x + step_x;
  assign fin_x      = finish(acc_a);
  assign fin_y      = finish(acc_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      rct_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = rct_pkg::ST_YTERM;
        end
      end
      rct_pkg::ST_YTERM: begin
        if (ph_end) begin
          state_next = rct_pkg::ST_XTERM;
        end
      end
      rct_pkg::ST_XTERM: begin
        if (ph_end) begin
          state_next = rct_pkg::ST_ROUND;
        end
      end
      rct_pkg::ST_ROUND: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = (count == CNT_W'(1)) ? rct_pkg::ST_IDLE : rct_pkg::ST_XTERM;
        end
      end
      default: begin
        state_next = rct_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop || ph_end || out_load) begin
        cnt <= '0;
      end else if (in_mul) begin
        cnt <= cnt + PH_W'(1);
      end
      if (q_pop) begin
        count <= q_cmd.count[CNT_W-1:0];
      end else if (out_load) begin
        count <= count - CNT_W'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      inv    <= q_cmd.inv;
      cur_x  <= XW'($signed(q_x));
      step_x <= XW'($signed(q_step));
      opnd   <= OPW'($signed(q_y));
      acc_a  <= off_a;
      acc_b  <= off_b;
    end
    if (issue) begin
      prod_c <= limb_s * cos_coef;
      prod_s <= limb_s * sin_coef;
      opnd   <= opnd >>> rct_pkg::LIMB_W;
    end
    if (in_mul) begin
      acc_a <= acc_a_next;
      acc_b <= acc_b_next;
    end
    // Hold the y-terms for the whole row, start on the first x
    if (ph_end && (state == rct_pkg::ST_YTERM)) begin
      held_a <= acc_a_next;
      held_b <= acc_b_next;
      opnd   <= OPW'(cur_x);
    end
    if (out_load) begin
      out_x    <= fin_x[COORD_WIDTH-1:0];
      out_y    <= fin_y[COORD_WIDTH-1:0];
      out_last <= (count == CNT_W'(1));
      out_sat  <= fin_x[COORD_WIDTH] | fin_y[COORD_WIDTH];
      cur_x    <= cur_x_next;
      opnd     <= OPW'(cur_x_next);
      acc_a    <= held_a;
      acc_b    <= held_b;
    end
  end

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (state == rct_pkg::ST_XTERM || state == rct_pkg::ST_ROUND) |-> (count != '0))
    else $error("x pass or rounding with no points left");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    in_mul |-> (cnt <= PH_W'(NCH)))
    else $error("limb counter past last limb");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (out_load && (count == CNT_W'(1))) |=> (state == rct_pkg::ST_IDLE && out_last))
    else $error("last result did not end the item");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == rct_pkg::ST_YTERM && cnt == '0))
    else $error("item pop did not start the y pass");

endmodule

// File: rtl/rigid_2d_coordinate_transform.sv
`timescale 1ns / 1ps

// Rigid 2D transform: rotation by a Q1.30 cosine/sine pair plus a translation, on
// signed Q.16 coordinates. Modes on s_tuser: direct point, inverse point, direct
// row, inverse row. A point gives one result beat; a row gives run_length beats
// (clipped to MAX_RUN, none for zero) with x stepping by x_step and the y-terms
// held exact, tlast on the final beat. Each result is rounded to nearest, ties up,
// and clipped; m_tuser flags a clip of either coordinate. Structure: a front stage
// classifies items into a two-entry queue, a back stage walks each product as
// 32-bit limbs through one pair of 33x32 multipliers. With L limbs
// (L = ceil((COORD_WIDTH + clog2(MAX_RUN) + 1) / 32), 2 at the defaults) per
// operand, the back stage runs a y pass per item, then an x pass and a rounding
// step per point. The result register lets the next point compute while a beat
// waits. Registers are to be written through the cfg port only while the block
// is idle, which the block itself does not enforce; cfg_ready is always high.

module rigid_2d_coordinate_transform #(
  parameter int MAX_RUN     = 64,
  parameter int COORD_WIDTH = 48
) (
  input  logic clk,
  input  logic rst,

  input  logic s_tvalid,
  output logic s_tready,
  // x_in, y_in, x_step, run_length; zero padded to bytes
  input  logic [((3*COORD_WIDTH + rct_pkg::RUN_W + 7)/8)*8-1:0] s_tdata,
  // mode
  input  logic [rct_pkg::MODE_W-1:0] s_tuser,

  output logic m_tvalid,
  input  logic m_tready,
  // x_out, y_out; zero padded to bytes
  output logic [((2*COORD_WIDTH + 7)/8)*8-1:0] m_tdata,
  output logic m_tlast,
  // saturated
  output logic [0:0] m_tuser,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rct_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [((COORD_WIDTH > rct_pkg::COEF_W) ? COORD_WIDTH : rct_pkg::COEF_W)-1:0] cfg_data
);

  localparam int OUT_W = ((2*COORD_WIDTH + 7)/8)*8;

  // Register file
  logic signed [rct_pkg::COEF_W-1:0] cos_coef;
  logic signed [rct_pkg::COEF_W-1:0] sin_coef;
  logic [COORD_WIDTH-1:0]            x_offset;
  logic [COORD_WIDTH-1:0]            y_offset;
  logic [COORD_WIDTH-1:0]            x_offset_inv;
  logic [COORD_WIDTH-1:0]            y_offset_inv;

  // Front to back queue
  logic                   q_valid;
  logic                   q_pop;
  rct_pkg::rct_cmd_t      q_cmd;
  logic [COORD_WIDTH-1:0] q_x;
  logic [COORD_WIDTH-1:0] q_y;
  logic [COORD_WIDTH-1:0] q_step;

  // Result register
  logic [COORD_WIDTH-1:0] out_x;
  logic [COORD_WIDTH-1:0] out_y;
  logic                   out_last;
  logic                   out_sat;

  // Writes are never held off; unknown indexes drop
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_coef     <= rct_pkg::COS_RESET;
      sin_coef     <= '0;
      x_offset     <= '0;
      y_offset     <= '0;
      x_offset_inv <= '0;
      y_offset_inv <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rct_pkg::REG_COS:       cos_coef     <= cfg_data[rct_pkg::COEF_W-1:0];
        rct_pkg::REG_SIN:       sin_coef     <= cfg_data[rct_pkg::COEF_W-1:0];
        rct_pkg::REG_X_OFF:     x_offset     <= cfg_data[COORD_WIDTH-1:0];
        rct_pkg::REG_Y_OFF:     y_offset     <= cfg_data[COORD_WIDTH-1:0];
        rct_pkg::REG_X_OFF_INV: x_offset_inv <= cfg_data[COORD_WIDTH-1:0];
        rct_pkg::REG_Y_OFF_INV: y_offset_inv <= cfg_data[COORD_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Accept, classify, queue
  rct_front #(
    .MAX_RUN     (MAX_RUN),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd),
    .q_x      (q_x),
    .q_y      (q_y),
    .q_step   (q_step)
  );

  // Multiply, accumulate, round, hold the result beat
  rct_engine #(
    .MAX_RUN     (MAX_RUN),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_cmd        (q_cmd),
    .q_x          (q_x),
    .q_y          (q_y),
    .q_step       (q_step),
    .cos_coef     (cos_coef),
    .sin_coef     (sin_coef),
    .x_offset     (x_offset),
    .y_offset     (y_offset),
    .x_offset_inv (x_offset_inv),
    .y_offset_inv (y_offset_inv),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_last     (out_last),
    .out_sat      (out_sat)
  );

  // Pack the result beat, x in the low bits
  assign m_tdata    = OUT_W'({out_y, out_x});
  assign m_tlast    = out_last;
  assign m_tuser[0] = out_sat;

endmodule

// File: tb/sv/tb_rigid_2d_coordinate_transform.sv
`timescale 1ns / 1ps

module tb_rigid_2d_coordinate_transform;

  localparam int COORD_W  = 48;
  localparam int RUN_MAX  = 64;
  localparam int S_DATA_W = ((3*COORD_W + rct_pkg::RUN_W + 7)/8)*8;
  localparam int M_DATA_W = ((2*COORD_W + 7)/8)*8;
  localparam int CFG_W    = (COORD_W > rct_pkg::COEF_W) ? COORD_W : rct_pkg::COEF_W;

  // Indexes past the last register; writes there must change nothing
  localparam logic [rct_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [rct_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [COORD_W-1:0] COORD_TOP = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_BOT = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [127:0] WIDE_TOP = 128'sh7FFF_FFFF_FFFF;
  localparam logic signed [127:0] WIDE_BOT = -128'sh8000_0000_0000;
  localparam logic signed [127:0] ROUND_HALF = 128'sd536870912;

  // Tail after the last result, long enough for a full row in the back stage
  localparam int TAIL_CYCLES  = 300;
  // Quiet time before a register write, covering zero-length rows still in flight
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;

  typedef enum {
    CFG_ROT45,
    CFG_MODERATE,
    CFG_EXTREME_A,
    CFG_EXTREME_B,
    CFG_FULL,
    CFG_IDENTITY
  } cfg_kind_t;

  typedef struct {
    logic [rct_pkg::MODE_W-1:0] mode;
    logic [COORD_W-1:0]         x;
    logic [COORD_W-1:0]         y;
    logic [COORD_W-1:0]         step;
    logic [rct_pkg::RUN_W-1:0]  run;
  } xform_item_t;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
    logic               sat;
  } coord_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // x_in, y_in, x_step, run_length, zero pad
  logic [S_DATA_W-1:0]   s_tdata = '0;
  // mode
  logic [rct_pkg::MODE_W-1:0] s_tuser = rct_pkg::MODE_DIR_PT;

  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // x_out, y_out
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  m_tlast;
  // saturated
  logic [0:0]            m_tuser;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [rct_pkg::REG_IDX_W-1:0] cfg_index = rct_pkg::REG_COS;
  logic [CFG_W-1:0]      cfg_data = '0;

  // Predictor copy of the register file
  logic [rct_pkg::COEF_W-1:0] rot_cos;
  logic [rct_pkg::COEF_W-1:0] rot_sin;
  logic [COORD_W-1:0]    shift_x;
  logic [COORD_W-1:0]    shift_y;
  logic [COORD_W-1:0]    shift_x_inv;
  logic [COORD_W-1:0]    shift_y_inv;

  xform_item_t   queued_items[$];
  coord_result_t expected_coords[$];
  xform_item_t   cur_item;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int mismatches   = 0;
  logic pressure_on = 1'b0;
  logic hold_used;
  int   hold_left;

  rigid_2d_coordinate_transform #(
    .MAX_RUN     (RUN_MAX),
    .COORD_WIDTH (COORD_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: exact wide arithmetic, then round half up and clip per coordinate
  // ---------------------------------------------------------------------------
  function automatic logic signed [127:0] ext_coord(logic [COORD_W-1:0] v);
    return {{(128-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [127:0] ext_coef(logic [rct_pkg::COEF_W-1:0] v);
    return {{(128-rct_pkg::COEF_W){v[rct_pkg::COEF_W-1]}}, v};
  endfunction

  // Bit COORD_W of the return flags a clip
  function automatic logic [COORD_W:0] round_clip(logic signed [127:0] v);
    logic signed [127:0] r;
    r = (v + ROUND_HALF) >>> rct_pkg::COEF_FRAC;
    if (r > WIDE_TOP) return {1'b1, COORD_TOP};
    if (r < WIDE_BOT) return {1'b1, COORD_BOT};
    return {1'b0, r[COORD_W-1:0]};
  endfunction

  function automatic void predict_transform(xform_item_t it);
    logic signed [127:0] px, py, pstep, c, s, tx, ty, xs, ys;
    logic [COORD_W:0]    rx, ry;
    logic                inv;
    int                  n;
    coord_result_t       r;
    inv   = (it.mode == rct_pkg::MODE_INV_PT) || (it.mode == rct_pkg::MODE_INV_ROW);
    px    = ext_coord(it.x);
    py    = ext_coord(it.y);
    pstep = ext_coord(it.step);
    c     = ext_coef(rot_cos);
    s     = ext_coef(rot_sin);
    // The y-terms and the offset are fixed for the whole item
    if (inv) begin
      tx = py * s + (ext_coord(shift_x_inv) <<< rct_pkg::COEF_FRAC);
      ty = py * c + (ext_coord(shift_y_inv) <<< rct_pkg::COEF_FRAC);
    end else begin
      tx = -(py * s) + (ext_coord(shift_x) <<< rct_pkg::COEF_FRAC);
      ty = py * c + (ext_coord(shift_y) <<< rct_pkg::COEF_FRAC);
    end
    if (it.mode == rct_pkg::MODE_DIR_ROW || it.mode == rct_pkg::MODE_INV_ROW) begin
      n = (it.run > RUN_MAX) ? RUN_MAX : int'(it.run);
    end else begin
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      xs = px * c + tx;
      ys = (inv ? -(px * s) : px * s) + ty;
      rx = round_clip(xs);
      ry = round_clip(ys);
      r.x    = rx[COORD_W-1:0];
      r.y    = ry[COORD_W-1:0];
      r.last = (k == n - 1);
      r.sat  = rx[COORD_W] | ry[COORD_W];
      expected_coords.push_back(r);
      // Row x stays exact; it is only clipped at the output
      px = px + pstep;
    end
  endfunction

  // Track register writes as the block sees them
  always @(posedge clk) begin
    if (rst) begin
      rot_cos     <= rct_pkg::COS_RESET;
      rot_sin     <= '0;
      shift_x     <= '0;
      shift_y     <= '0;
      shift_x_inv <= '0;
      shift_y_inv <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rct_pkg::REG_COS:       rot_cos     <= cfg_data[rct_pkg::COEF_W-1:0];
        rct_pkg::REG_SIN:       rot_sin     <= cfg_data[rct_pkg::COEF_W-1:0];
        rct_pkg::REG_X_OFF:     shift_x     <= cfg_data[COORD_W-1:0];
        rct_pkg::REG_Y_OFF:     shift_y     <= cfg_data[COORD_W-1:0];
        rct_pkg::REG_X_OFF_INV: shift_x_inv <= cfg_data[COORD_W-1:0];
        rct_pkg::REG_Y_OFF_INV: shift_y_inv <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input driver: predict on each accepted beat, then present the next item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_transform(cur_item);
      // Advance only when the current beat is gone or none is up
      if (!s_tvalid || s_tready) begin
        if (queued_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_item = queued_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(S_DATA_W-3*COORD_W-rct_pkg::RUN_W){1'b0}},
                       cur_item.run, cur_item.step, cur_item.y, cur_item.x};
          s_tuser  <= cur_item.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output ready: random stalls, plus one long hold-off once pressure is asked
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (pressure_on && !hold_used) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Output checker
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(string what, coord_result_t want,
                                        coord_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected x=%h y=%h last=%b sat=%b, got x=%h y=%h last=%b sat=%b",
               $realtime, what, want.x, want.y, want.last, want.sat,
               got.x, got.y, got.last, got.sat);
    end
  endfunction

  always @(posedge clk) begin : check_results
    coord_result_t want;
    coord_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.x    = m_tdata[COORD_W-1:0];
      got.y    = m_tdata[2*COORD_W-1:COORD_W];
      got.last = m_tlast;
      got.sat  = m_tuser[0];
      if (expected_coords.size() == 0) begin
        want = '{x: '0, y: '0, last: 1'b0, sat: 1'b0};
        note_mismatch("unexpected beat", want, got);
      end else begin
        want = expected_coords.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
            got.sat !== want.sat) begin
          note_mismatch("wrong beat", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_item(logic [rct_pkg::MODE_W-1:0] mode, logic [COORD_W-1:0] x,
                            logic [COORD_W-1:0] y, logic [COORD_W-1:0] step,
                            logic [rct_pkg::RUN_W-1:0] run);
    xform_item_t it;
    it.mode = mode;
    it.x    = x;
    it.y    = y;
    it.step = step;
    it.run  = run;
    queued_items.push_back(it);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    logic [31:0] hi, lo;
    hi = $urandom;
    lo = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: return {{(COORD_W-24){lo[23]}}, lo[23:0]};
      4, 5:       return {{(COORD_W-36){hi[3]}}, hi[3:0], lo};
      6, 7:       return {hi[COORD_W-33:0], lo};
      8: begin
        case (hi[1:0])
          2'd0: return COORD_TOP;
          2'd1: return COORD_BOT;
          2'd2: return '0;
          default: return '1;
        endcase
      end
      default: return {{(COORD_W-16){lo[15]}}, lo[15:0]};
    endcase
  endfunction

  // Keep most steps small so rows stay in range for a while
  function automatic logic [COORD_W-1:0] rand_step();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5, 6: return {{(COORD_W-17){v[16]}}, v[16:0]};
      7, 8:                return {{(COORD_W-24){v[23]}}, v[23:0]};
      default:             return rand_coord();
    endcase
  endfunction

  function automatic logic [rct_pkg::RUN_W-1:0] rand_run();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5, 6: return rct_pkg::RUN_W'($urandom_range(8));
      7, 8:                return rct_pkg::RUN_W'($urandom_range(63));
      default:             return rct_pkg::RUN_W'($urandom_range(127, 64));
    endcase
  endfunction

  task automatic queue_random_item();
    logic [rct_pkg::MODE_W-1:0] mode;
    logic                       inv;
    inv = 1'($urandom_range(1));
    if ($urandom_range(9) < 4) mode = inv ? rct_pkg::MODE_INV_PT : rct_pkg::MODE_DIR_PT;
    else mode = inv ? rct_pkg::MODE_INV_ROW : rct_pkg::MODE_DIR_ROW;
    queue_item(mode, rand_coord(), rand_coord(), rand_step(), rand_run());
  endtask

  task automatic write_reg(logic [rct_pkg::REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Wait until nothing is offered or owed, then let stray zero-length rows finish
  task automatic drain();
    do @(posedge clk);
    while (queued_items.size() != 0 || s_tvalid || expected_coords.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(cfg_kind_t kind);
    logic [rct_pkg::COEF_W-1:0] c, s;
    logic [COORD_W-1:0] ox, oy, oxi, oyi;
    logic [31:0]        junk, t0, t1;
    junk = $urandom;
    t0   = $urandom;
    t1   = $urandom;
    case (kind)
      CFG_ROT45: begin
        c   = 32'h2D41_3CCD;  // +0.7071
        s   = 32'hD2BE_C333;  // -0.7071
        ox  = 48'h0000_0012_8000;
        oy  = 48'hFFFF_FFF3_4000;
        oxi = 48'hFFFF_FF80_0001;
        oyi = 48'h0000_0100_FFFF;
      end
      CFG_MODERATE: begin
        c   = {t0[30], t0[30:0]};
        s   = {t1[30], t1[30:0]};
        ox  = rand_coord();
        oy  = rand_coord();
        oxi = rand_coord();
        oyi = rand_coord();
      end
      CFG_EXTREME_A: begin
        c   = {1'b1, {(rct_pkg::COEF_W-1){1'b0}}};
        s   = {1'b0, {(rct_pkg::COEF_W-1){1'b1}}};
        ox  = COORD_TOP;
        oy  = COORD_BOT;
        oxi = COORD_TOP;
        oyi = COORD_BOT;
      end
      CFG_EXTREME_B: begin
        c   = {1'b0, {(rct_pkg::COEF_W-1){1'b1}}};
        s   = {1'b1, {(rct_pkg::COEF_W-1){1'b0}}};
        ox  = COORD_BOT;
        oy  = COORD_TOP;
        oxi = COORD_BOT;
        oyi = COORD_TOP;
      end
      CFG_FULL: begin
        c   = t0;
        s   = t1;
        ox  = rand_coord();
        oy  = rand_coord();
        oxi = rand_coord();
        oyi = rand_coord();
      end
      default: begin
        c   = rct_pkg::COS_RESET;
        s   = '0;
        ox  = '0;
        oy  = '0;
        oxi = '0;
        oyi = '0;
      end
    endcase
    @(posedge clk);
    // Upper data bits are junk on the coefficient writes; the block keeps 32 bits
    write_reg(rct_pkg::REG_COS, {junk[CFG_W-rct_pkg::COEF_W-1:0], c});
    write_reg(rct_pkg::REG_SIN, {junk[31:32-(CFG_W-rct_pkg::COEF_W)], s});
    write_reg(rct_pkg::REG_X_OFF, ox);
    write_reg(rct_pkg::REG_Y_OFF, oy);
    write_reg(rct_pkg::REG_X_OFF_INV, oxi);
    write_reg(rct_pkg::REG_Y_OFF_INV, oyi);
    write_reg(REG_SPARE_LO, rand_coord());
    write_reg(REG_SPARE_HI, rand_coord());
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(cfg_kind_t kind, int src_pct, int snk_pct, int count);
    load_config(kind);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (count) queue_random_item();
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct = 38;
    snk_idle_pct = 80;

    // Reset values of the registers: identity rotation, no offset
    queue_item(rct_pkg::MODE_DIR_PT, 48'h0000_0001_8000, 48'hFFFF_FFFE_0000, '0, '0);
    queue_item(rct_pkg::MODE_INV_PT, 48'h0000_0000_4000, 48'h0000_0000_C000,
               48'h1234, 7'd9);
    drain();

    load_config(CFG_ROT45);
    queue_item(rct_pkg::MODE_DIR_PT, 48'h0000_0003_8000, 48'h0000_0002_0000, '0, '0);
    queue_item(rct_pkg::MODE_INV_PT, 48'hFFFF_FFFC_8000, 48'h0000_0007_0001, '0, '0);
    queue_item(rct_pkg::MODE_DIR_PT, COORD_TOP, COORD_BOT, '0, '0);
    queue_item(rct_pkg::MODE_INV_PT, COORD_BOT, COORD_TOP, '0, '0);
    // Point modes ignore step and run length
    queue_item(rct_pkg::MODE_DIR_PT, COORD_TOP, COORD_TOP, COORD_BOT, 7'd127);
    queue_item(rct_pkg::MODE_INV_PT, '0, '0, COORD_TOP, 7'd64);
    queue_item(rct_pkg::MODE_DIR_ROW, 48'h0000_0010_0000, 48'h0000_0005_0000,
               48'h0000_0000_8000, 7'd1);
    queue_item(rct_pkg::MODE_INV_ROW, 48'hFFFF_FFF0_0000, 48'h0000_0020_0000,
               48'h0000_0001_4000, 7'd5);
    // Zero-length rows produce nothing
    queue_item(rct_pkg::MODE_DIR_ROW, 48'h0000_0001_0000, 48'h0000_0001_0000,
               48'h0000_0001_0000, 7'd0);
    queue_item(rct_pkg::MODE_INV_ROW, COORD_TOP, COORD_BOT, COORD_TOP, 7'd0);
    queue_item(rct_pkg::MODE_DIR_ROW, 48'hFFFF_FFE0_0000, 48'h0000_0003_0000,
               48'h0000_0000_0101, 7'd64);
    // Runs above the maximum clip to it
    queue_item(rct_pkg::MODE_INV_ROW, 48'h0000_0100_0000, 48'hFFFF_FF00_0000,
               48'hFFFF_FFFF_C000, 7'd127);
    queue_item(rct_pkg::MODE_DIR_ROW, 48'h0000_0000_0001, 48'hFFFF_FFFF_FFFF,
               48'h0000_0000_0003, 7'd65);
    // Row x runs past the coordinate range; only the outputs clip
    queue_item(rct_pkg::MODE_DIR_ROW, 48'h7FFF_0000_0000, 48'h0000_0004_0000,
               48'h0800_0000_0000, 7'd10);
    queue_item(rct_pkg::MODE_INV_ROW, COORD_BOT, COORD_TOP, COORD_BOT, 7'd8);
    queue_item(rct_pkg::MODE_DIR_PT, '1, '1, '0, '0);
    drain();

    run_phase(CFG_MODERATE,  38, 80, 44);
    run_phase(CFG_EXTREME_A, 38, 80, 44);
    run_phase(CFG_FULL,      80, 38, 44);
    run_phase(CFG_EXTREME_B, 80, 38, 44);
    // Sender keeps offering while the receiver holds off long enough to back up
    pressure_on = 1'b1;
    run_phase(CFG_MODERATE,   0,  0, 44);
    run_phase(CFG_IDENTITY,   0,  0, 44);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_coords.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
